### rtl/plst_pkg.sv
// Shared types and constants for the positional list store.
// Holds the request and status codes and the command struct fed to every cell.
// No dependencies.
package plst_pkg;

    // Default list capacity
    localparam int LIST_DEPTH_DEF = 16;

    // Field widths fixed by the stream format
    localparam int MODE_W  = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Command broadcast to the cell chain in each cycle
    typedef struct packed {
        logic             insert_en;
        logic             remove_en;
        logic [POS_W-1:0] pos_idx;    // zero-based target position
    } plst_cmd_t;

endpackage

### rtl/plst_cell.sv
// One storage cell of the list chain: holds one entry and trades it with
// its neighbors on insert and remove. Depends on plst_pkg.
module plst_cell #(
    parameter int IDX = 0
) (
    input  logic                        aclk,
    input  plst_pkg::plst_cmd_t         cmd,
    input  logic [plst_pkg::DATA_W-1:0] ins_value,
    input  logic [plst_pkg::DATA_W-1:0] left_data,
    input  logic [plst_pkg::DATA_W-1:0] right_data,
    output logic [plst_pkg::DATA_W-1:0] data
);
    import plst_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Load, take a neighbor's entry, or hold
    always_comb begin
        data_next = data_reg;
        if (cmd.insert_en) begin
            if (IDX == int'(cmd.pos_idx)) begin
                data_next = ins_value;
            end else if (IDX > int'(cmd.pos_idx)) begin
                data_next = left_data;
            end
        end else if (cmd.remove_en && (IDX >= int'(cmd.pos_idx))) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/positional_list_store_unit.sv
// Top level of the positional list store: request decode, count register,
// cell chain and result register. Depends on plst_pkg and plst_cell.
// Result: registered, and it appears on m_ in the cycle after its request transfer.
// Throughput: one request per cycle while the result slot is free or draining; the whole chain shifts at once.
// Reset: aresetn (synchronous, active low) empties the list and the result
// register; entry contents are not cleared and are read only once written.
module positional_list_store_unit #(
    parameter int LIST_DEPTH = plst_pkg::LIST_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[1:0], position[6:2], item_value[38:7], zero [39]
    input  logic [plst_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value[31:0], entry_count[36:32], status[38:37], zero [39]
    output logic [plst_pkg::M_TDATA_W-1:0] m_tdata
);
    import plst_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Request fields
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;

    assign mode       = s_tdata[MODE_W-1:0];
    assign position   = s_tdata[MODE_W+POS_W-1:MODE_W];
    assign item_value = s_tdata[MODE_W+POS_W+DATA_W-1:MODE_W+POS_W];

    logic s_accept;
    logic m_accept;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [CNT_W-1:0]  cnt_out_next;
    status_t           st_reg;
    status_t           st_next;

    plst_cmd_t         cmd;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              pos_zero;
    logic              full;
    logic [DATA_W-1:0] sel_data;

    logic [DATA_W-1:0] cell_data [LIST_DEPTH];

    // Accept a new request whenever the result slot is free or draining, never in reset
    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_valid_reg && m_tready;

    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_zero = (position == '0);
    assign full     = (count_reg == CNT_W'(LIST_DEPTH));

    // Pick the entry at the requested position
    always_comb begin
        sel_data = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (i == int'(cmd.pos_idx)) begin
                sel_data = cell_data[i];
            end
        end
    end

    // Decode the request, check bounds, drive the chain command
    always_comb begin
        cmd.insert_en = 1'b0;
        cmd.remove_en = 1'b0;
        cmd.pos_idx   = position - POS_W'(1);
        count_next    = count_reg;
        rd_next       = rd_reg;
        cnt_out_next  = cnt_out_reg;
        st_next       = st_reg;
        m_valid_next  = m_valid_reg;

        if (m_accept) begin
            m_valid_next = 1'b0;
        end

        if (s_accept) begin
            m_valid_next = 1'b1;
            rd_next      = '0;
            st_next      = ST_OK;
            unique case (mode)
                MODE_INSERT: begin
                    if (pos_zero || (pos_ext > cnt_ext + CMP_W'(1))) begin
                        st_next = ST_OOB;
                    end else if (full) begin
                        st_next = ST_FULL;
                    end else begin
                        cmd.insert_en = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (pos_zero || (pos_ext > cnt_ext)) begin
                        st_next = ST_OOB;
                    end else begin
                        cmd.remove_en = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                MODE_READ: begin
                    if (pos_zero || (pos_ext > cnt_ext)) begin
                        st_next = ST_OOB;
                    end else begin
                        rd_next = sel_data;
                    end
                end
                default: begin
                    st_next = ST_OOB;
                end
            endcase
            cnt_out_next = count_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        rd_reg      <= rd_next;
        cnt_out_reg <= cnt_out_next;
        st_reg      <= st_next;
    end

    // Cell chain
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_last
            assign right_w = cell_data[g];
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        plst_cell #(
            .IDX(g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .ins_value (item_value),
            .left_data (left_w),
            .right_data(right_w),
            .data      (cell_data[g])
        );
    end

    // Pack the result transfer
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, st_reg, COUNT_W'(cnt_out_reg), rd_reg};

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count above capacity");

    // Every request transfer yields a pending result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("request transfer produced no result");

    // A successful insert grows the list by one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && cmd.insert_en) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // A rejected request reports zero data and leaves the count unchanged
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (st_next != ST_OK)) |=> ((rd_reg == '0) && $stable(count_reg)))
        else $error("rejected request changed state or data");

    // Only one chain operation at a time
    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.insert_en && cmd.remove_en))
        else $error("insert and remove issued together");

endmodule
